// ===== design/rgbc_pkg.sv =====
// Shared types and constants for the RGB 3x3 convolution block.
// No dependencies; every other design file imports this package.
package rgbc_pkg;

   localparam int MAX_WIDTH   = 2048;
   localparam int MAX_HEIGHT  = 4096;
   localparam int COEF_BITS   = 16;
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
   localparam int WCFG_BITS   = 12;
   localparam int HCFG_BITS   = 13;
   localparam int KROW_BITS   = 3 * COEF_BITS;
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int PROD_BITS   = COEF_BITS + 9;
   localparam int RSUM_BITS   = PROD_BITS + 2;
   localparam int TSUM_BITS   = RSUM_BITS + 2;

   localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [2:0] REG_KERNEL_TOP   = 3'd2;
   localparam logic [2:0] REG_KERNEL_MID   = 3'd3;
   localparam logic [2:0] REG_KERNEL_BOT   = 3'd4;
   localparam logic [2:0] REG_GRAY         = 3'd5;
   localparam logic [2:0] REG_OFFSET       = 3'd6;

   // Window word handed from front to back
   typedef struct packed {
      logic [8:0][23:0] win;
      logic             last;
   } win_item_type;

   // Result word held in the output queue
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } rsp_item_type;

   // Occupancy of the pipeline stages, used for admission control
   typedef struct packed {
      logic stage_a;
      logic stage_b;
   } busy_type;

endpackage

// ===== design/rgbc_front.sv =====
// Front end: raster counters, gray conversion, two line stores and the 3x3 window.
// Depends on rgbc_pkg.
module rgbc_front import rgbc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           pix_red,
   input  logic [7:0]           pix_green,
   input  logic [7:0]           pix_blue,
   input  logic [WCFG_BITS-1:0] width_cfg,
   input  logic [HCFG_BITS-1:0] height_cfg,
   input  logic                 gray_cfg,
   output logic                 item_valid,
   output win_item_type         item,
   output busy_type             busy
);

   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [WCFG_BITS-1:0] w;
   logic [HCFG_BITS-1:0] h;
   logic [WCFG_BITS-1:0] c, cn;
   logic [HCFG_BITS-1:0] r, rn;
   logic [15:0] lum;
   logic [23:0] pix;
   logic emit, last;

   logic [23:0] older_mem [MAX_WIDTH];
   logic [23:0] newer_mem [MAX_WIDTH];
   logic [23:0] older_rd_ff, newer_rd_ff;

   logic                s1_valid_ff;
   logic [23:0]         s1_pix_ff;
   logic [COL_BITS-1:0] s1_col_ff;
   logic                s1_emit_ff, s1_last_ff;

   logic [8:0][23:0] win_ff;
   logic             win_valid_ff, win_last_ff;

   // Clamp the image size to the supported range
   always_comb begin
      if (width_cfg < WCFG_BITS'(3)) w = WCFG_BITS'(3);
      else if (width_cfg > WCFG_BITS'(MAX_WIDTH)) w = WCFG_BITS'(MAX_WIDTH);
      else w = width_cfg;
      if (height_cfg < HCFG_BITS'(3)) h = HCFG_BITS'(3);
      else if (height_cfg > HCFG_BITS'(MAX_HEIGHT)) h = HCFG_BITS'(MAX_HEIGHT);
      else h = height_cfg;
   end

   // Convert to luminance when asked
   always_comb begin
      lum = 16'(pix_red) * 16'd77 + 16'(pix_green) * 16'd150 + 16'(pix_blue) * 16'd29;
      if (gray_cfg) pix = {lum[15:8], lum[15:8], lum[15:8]};
      else pix = {pix_blue, pix_green, pix_red};
   end

   // Place the pixel in the raster and work out the next position
   always_comb begin
      c = WCFG_BITS'(col_ff);
      r = HCFG_BITS'(row_ff);
      if (c >= w) begin
         c = '0;
         r = r + 1'b1;
      end
      if (r >= h) r = '0;
      emit = (r >= HCFG_BITS'(2)) && (c >= WCFG_BITS'(2));
      last = (r == h - 1'b1) && (c == w - 1'b1);
      cn = c + 1'b1;
      rn = r;
      if (cn >= w) begin
         cn = '0;
         rn = r + 1'b1;
         if (rn >= h) rn = '0;
      end
      col_in = cn[COL_BITS-1:0];
      row_in = rn[ROW_BITS-1:0];
   end

   // Advance counters and stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         win_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         s1_valid_ff  <= accept;
         win_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   // Read both line stores at the pixel's column
   always_ff @(posedge clock) begin
      if (accept) begin
         older_rd_ff <= older_mem[c[COL_BITS-1:0]];
         newer_rd_ff <= newer_mem[c[COL_BITS-1:0]];
         s1_pix_ff   <= pix;
         s1_col_ff   <= c[COL_BITS-1:0];
         s1_emit_ff  <= emit;
         s1_last_ff  <= last;
      end
   end

   // Roll the line stores and shift the window
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         older_mem[s1_col_ff] <= newer_rd_ff;
         newer_mem[s1_col_ff] <= s1_pix_ff;
         for (int k = 0; k < 3; k++) begin
            win_ff[k*3+0] <= win_ff[k*3+1];
            win_ff[k*3+1] <= win_ff[k*3+2];
         end
         win_ff[2]   <= older_rd_ff;
         win_ff[5]   <= newer_rd_ff;
         win_ff[8]   <= s1_pix_ff;
         win_last_ff <= s1_last_ff;
      end
   end

   assign item_valid    = win_valid_ff;
   assign item.win      = win_ff;
   assign item.last     = win_last_ff;
   assign busy.stage_a  = s1_valid_ff;
   assign busy.stage_b  = win_valid_ff;

endmodule

// ===== design/rgbc_back.sv =====
// Back end: 27 tap products, row sums, truncation, offset and clamp.
// Depends on rgbc_pkg.
module rgbc_back import rgbc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      item_valid,
   input  win_item_type              item,
   input  logic [2:0][KROW_BITS-1:0] kernel,
   input  logic                      offset_cfg,
   output logic                      push,
   output rsp_item_type              result,
   output busy_type                  busy
);

   logic signed [PROD_BITS-1:0] prod_in [3][9];
   logic signed [PROD_BITS-1:0] prod_ff [3][9];
   logic signed [RSUM_BITS-1:0] rsum_in [3][3];
   logic signed [RSUM_BITS-1:0] rsum_ff [3][3];
   logic v1_ff, v2_ff, last1_ff, last2_ff;
   logic [2:0][7:0] chan;
   logic signed [TSUM_BITS-1:0] total;
   logic signed [TSUM_BITS-9:0] quo;
   logic signed [TSUM_BITS-8:0] res;

   // Multiply each tap by its flipped coefficient
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         for (int y = 0; y < 3; y++) begin
            for (int x = 0; x < 3; x++) begin
               prod_in[ch][y*3+x] = $signed({1'b0, item.win[y*3+x][ch*8 +: 8]})
                  * $signed(kernel[2-y][(2-x)*COEF_BITS +: COEF_BITS]);
            end
         end
      end
   end

   // Add the three taps of each window row
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         for (int y = 0; y < 3; y++) begin
            rsum_in[ch][y] = RSUM_BITS'(prod_ff[ch][y*3]) + RSUM_BITS'(prod_ff[ch][y*3+1])
               + RSUM_BITS'(prod_ff[ch][y*3+2]);
         end
      end
   end

   // Finish each channel: total, truncate toward zero, offset, clamp
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         total = TSUM_BITS'(rsum_ff[ch][0]) + TSUM_BITS'(rsum_ff[ch][1])
            + TSUM_BITS'(rsum_ff[ch][2]);
         if (total < 0) total = total + TSUM_BITS'(255);
         quo = total[TSUM_BITS-1:8];
         res = (TSUM_BITS-7)'(quo) + (offset_cfg ? (TSUM_BITS-7)'(127) : '0);
         if (res < 0) chan[ch] = 8'd0;
         else if (res > (TSUM_BITS-7)'(255)) chan[ch] = 8'd255;
         else chan[ch] = res[7:0];
      end
   end

   // Advance the stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= item_valid;
         v2_ff <= v1_ff;
      end
   end

   // Hold products and row sums
   always_ff @(posedge clock) begin
      if (item_valid) begin
         prod_ff  <= prod_in;
         last1_ff <= item.last;
      end
      if (v1_ff) begin
         rsum_ff  <= rsum_in;
         last2_ff <= last1_ff;
      end
   end

   assign push         = v2_ff;
   assign result.red   = chan[0];
   assign result.green = chan[1];
   assign result.blue  = chan[2];
   assign result.last  = last2_ff;
   assign busy.stage_a = v1_ff;
   assign busy.stage_b = v2_ff;

endmodule

// ===== design/rgbc_queue.sv =====
// Result queue between the filter pipeline and the output channel.
// Depends on rgbc_pkg.
module rgbc_queue import rgbc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rsp_item_type       push_item,
   input  logic               pop,
   output logic               not_empty,
   output rsp_item_type       head,
   output logic [QPTR_BITS:0] count
);

   rsp_item_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ff, rd_ff;
   logic [QPTR_BITS:0]   count_ff;

   // Store pushed words, advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         count_ff <= count_ff + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_item;
   end

   assign not_empty = count_ff != '0;
   assign head      = slot_ff[rd_ff];
   assign count     = count_ff;

endmodule

// ===== design/rgb_convolution_3x3_top.sv =====
// Top level: register port, front end, filter back end and result queue.
// One pixel per cycle sustained while admission does not stall. Each line store does one
// read and one write a cycle, and a 4-stage pipeline feeds an 8-word queue; admission
// stalls when queue plus in-flight words reach 8. Reset (synchronous) clears counters,
// valids and queue and loads register defaults. Depends on rgbc_pkg, rgbc_front,
// rgbc_back, rgbc_queue.
module rgb_convolution_3x3_top import rgbc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_pix_red,
   input  logic [7:0]  req_pix_green,
   input  logic [7:0]  req_pix_blue,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   output logic        rsp_frame_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   logic [WCFG_BITS-1:0]      width_ff;
   logic [HCFG_BITS-1:0]      height_ff;
   logic [2:0][KROW_BITS-1:0] kernel_ff;
   logic                      gray_ff, offset_ff;
   logic [2:0]                reg_idx;
   logic                      wr_en, accept, pop;
   logic                      win_valid, push;
   win_item_type              win_item;
   rsp_item_type              result, head;
   busy_type                  front_busy, back_busy;
   logic [QPTR_BITS:0]        q_count;
   logic [QPTR_BITS+1:0]      pending;

   assign reg_idx = paddr[5:3];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WCFG_BITS'(640);
         height_ff <= HCFG_BITS'(480);
         kernel_ff <= {KROW_BITS'(0), KROW_BITS'(256), KROW_BITS'(0)};
         gray_ff   <= 1'b0;
         offset_ff <= 1'b0;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_IMAGE_WIDTH:  width_ff     <= pwdata[WCFG_BITS-1:0];
            REG_IMAGE_HEIGHT: height_ff    <= pwdata[HCFG_BITS-1:0];
            REG_KERNEL_TOP:   kernel_ff[0] <= pwdata[KROW_BITS-1:0];
            REG_KERNEL_MID:   kernel_ff[1] <= pwdata[KROW_BITS-1:0];
            REG_KERNEL_BOT:   kernel_ff[2] <= pwdata[KROW_BITS-1:0];
            REG_GRAY:         gray_ff      <= pwdata[0];
            REG_OFFSET:       offset_ff    <= pwdata[0];
            default: ;
         endcase
      end
   end

   // Read back registers
   always_comb begin
      unique case (reg_idx)
         REG_IMAGE_WIDTH:  prdata = 64'(width_ff);
         REG_IMAGE_HEIGHT: prdata = 64'(height_ff);
         REG_KERNEL_TOP:   prdata = 64'(kernel_ff[0]);
         REG_KERNEL_MID:   prdata = 64'(kernel_ff[1]);
         REG_KERNEL_BOT:   prdata = 64'(kernel_ff[2]);
         REG_GRAY:         prdata = 64'(gray_ff);
         REG_OFFSET:       prdata = 64'(offset_ff);
         default:          prdata = '0;
      endcase
   end

   // Admit a word only when the queue has room for everything in flight
   assign pending = (QPTR_BITS+2)'(q_count) + (QPTR_BITS+2)'(front_busy.stage_a)
      + (QPTR_BITS+2)'(front_busy.stage_b) + (QPTR_BITS+2)'(back_busy.stage_a)
      + (QPTR_BITS+2)'(back_busy.stage_b);
   assign req_stall = pending >= (QPTR_BITS+2)'(QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   rgbc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .pix_red    (req_pix_red),
      .pix_green  (req_pix_green),
      .pix_blue   (req_pix_blue),
      .width_cfg  (width_ff),
      .height_cfg (height_ff),
      .gray_cfg   (gray_ff),
      .item_valid (win_valid),
      .item       (win_item),
      .busy       (front_busy)
   );

   rgbc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (win_valid),
      .item       (win_item),
      .kernel     (kernel_ff),
      .offset_cfg (offset_ff),
      .push       (push),
      .result     (result),
      .busy       (back_busy)
   );

   rgbc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (result),
      .pop       (pop),
      .not_empty (rsp_valid),
      .head      (head),
      .count     (q_count)
   );

   assign rsp_out_red    = head.red;
   assign rsp_out_green  = head.green;
   assign rsp_out_blue   = head.blue;
   assign rsp_frame_last = head.last;

   // Queue plus in-flight words never exceed the queue depth
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      pending <= (QPTR_BITS+2)'(QUEUE_DEPTH))
      else $error("result queue overflow");

   // Queue is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // An accepted word always occupies the first front stage next cycle
   a_accept_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> front_busy.stage_a)
      else $error("accepted word lost");

endmodule

// ===== sim/rgb_convolution_3x3_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the RGB 3x3 convolution block: a line-store and window
// predictor, a clocked driver and monitor, and a register writer. Depends on rgbc_pkg.
module rgb_convolution_3x3_top_test;
   import rgbc_pkg::*;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_word_type;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } filtered_word_type;

   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_pix_red = '0;
   logic [7:0]  req_pix_green = '0;
   logic [7:0]  req_pix_blue = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_red;
   logic [7:0]  rsp_out_green;
   logic [7:0]  rsp_out_blue;
   logic        rsp_frame_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [5:0]  paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic        pready;

   rgb_convolution_3x3_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_pix_red(req_pix_red), .req_pix_green(req_pix_green),
      .req_pix_blue(req_pix_blue),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_red(rsp_out_red), .rsp_out_green(rsp_out_green),
      .rsp_out_blue(rsp_out_blue), .rsp_frame_last(rsp_frame_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Register mirror
   logic [11:0]          cfg_width;
   logic [12:0]          cfg_height;
   logic [KROW_BITS-1:0] cfg_kernel [3];
   logic                 cfg_gray;
   logic                 cfg_offset;

   // Predictor state
   logic [23:0] older_line [MAX_WIDTH];
   logic [23:0] newer_line [MAX_WIDTH];
   logic [23:0] window [9];
   int          col_pos;
   int          row_pos;

   pixel_word_type    pending_pixels [$];
   filtered_word_type expected_words [$];
   int                mismatch_count = 0;
   int                idle_cycles = 0;
   logic              pix_taken = 1'b0;
   int                burst_left = 0;
   int                gap_left = 0;
   int                cycle_count = 0;

   function automatic int clamp_size(int v, int hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
   endfunction

   // Convolve one channel of the window with the flipped kernel, then offset and clamp
   function automatic logic [7:0] convolve_channel(int shift);
      longint acc;
      longint coef;
      longint res;
      acc = 0;
      for (int y = 0; y < 3; y++)
         for (int x = 0; x < 3; x++) begin
            coef = longint'($signed(cfg_kernel[2-y][(2-x)*COEF_BITS +: COEF_BITS]));
            acc += longint'(window[y*3+x][shift +: 8]) * coef;
         end
      res = acc / 256;
      if (cfg_offset) res += 127;
      if (res < 0) res = 0;
      if (res > 255) res = 255;
      return res[7:0];
   endfunction

   // Advance the line stores and window by one pixel; queue a word for interior pixels
   task automatic predict_pixel(input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b);
      int w;
      int h;
      int col;
      int row;
      int lum;
      logic [23:0] pix;
      logic [23:0] up2;
      logic [23:0] up1;
      filtered_word_type word;
      w = clamp_size(int'(cfg_width), MAX_WIDTH);
      h = clamp_size(int'(cfg_height), MAX_HEIGHT);
      if (cfg_gray) begin
         lum = (77 * r + 150 * g + 29 * b) >> 8;
         pix = {3{lum[7:0]}};
      end else begin
         pix = {b, g, r};
      end
      col = col_pos;
      row = row_pos;
      if (col >= w) begin
         col = 0;
         row++;
      end
      if (row >= h) row = 0;
      up2 = older_line[col];
      up1 = newer_line[col];
      older_line[col] = up1;
      newer_line[col] = pix;
      for (int k = 0; k < 3; k++) begin
         window[k*3] = window[k*3+1];
         window[k*3+1] = window[k*3+2];
      end
      window[2] = up2;
      window[5] = up1;
      window[8] = pix;
      if (row >= 2 && col >= 2) begin
         word.red = convolve_channel(0);
         word.green = convolve_channel(8);
         word.blue = convolve_channel(16);
         word.last = (row == h - 1) && (col == w - 1);
         expected_words.push_back(word);
      end
      col++;
      if (col >= w) begin
         col = 0;
         row++;
         if (row >= h) row = 0;
      end
      col_pos = col;
      row_pos = row;
   endtask

   // Accept side: predict each accepted pixel, check each accepted result word
   always @(posedge clock) begin
      filtered_word_type want;
      pix_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall)
            predict_pixel(req_pix_red, req_pix_green, req_pix_blue);
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected word: r=%0d g=%0d b=%0d last=%0b",
                           rsp_out_red, rsp_out_green, rsp_out_blue, rsp_frame_last);
            end else begin
               want = expected_words.pop_front();
               if (want.red !== rsp_out_red || want.green !== rsp_out_green ||
                   want.blue !== rsp_out_blue || want.last !== rsp_frame_last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"mismatch: expected r=%0d g=%0d b=%0d last=%0b, ",
                               "got r=%0d g=%0d b=%0d last=%0b"},
                              want.red, want.green, want.blue, want.last,
                              rsp_out_red, rsp_out_green, rsp_out_blue, rsp_frame_last);
               end
            end
         end
         // Watchdog: count cycles in which neither channel moves a word and psel is low
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Pixel driver: bursts of random length separated by random gaps
   always @(negedge clock) begin
      pixel_word_type next_pix;
      if (!reset && (!req_valid || pix_taken)) begin
         if (burst_left > 0 && pending_pixels.size() > 0) begin
            next_pix = pending_pixels.pop_front();
            req_pix_red <= next_pix.red;
            req_pix_green <= next_pix.green;
            req_pix_blue <= next_pix.blue;
            req_valid <= 1'b1;
            burst_left <= burst_left - 1;
         end else begin
            req_valid <= 1'b0;
            if (burst_left == 0) begin
               if (gap_left > 0) begin
                  gap_left <= gap_left - 1;
               end else begin
                  burst_left <= $urandom_range(1, 64);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
      end
   end

   // Result stall pattern: rotate among no stall, heavy, periodic and light stalling
   always @(negedge clock) begin
      cycle_count <= cycle_count + 1;
      case ((cycle_count >> 9) % 4)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 1) == 1);
         2: rsp_stall <= ((cycle_count % 16) < 11);
         default: rsp_stall <= ($urandom_range(0, 7) == 0);
      endcase
   end

   task automatic csr_write(input logic [2:0] index, input logic [63:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 3'b000};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         REG_IMAGE_WIDTH:  cfg_width = value[11:0];
         REG_IMAGE_HEIGHT: cfg_height = value[12:0];
         REG_KERNEL_TOP:   cfg_kernel[0] = value[KROW_BITS-1:0];
         REG_KERNEL_MID:   cfg_kernel[1] = value[KROW_BITS-1:0];
         REG_KERNEL_BOT:   cfg_kernel[2] = value[KROW_BITS-1:0];
         REG_GRAY:         cfg_gray = value[0];
         REG_OFFSET:       cfg_offset = value[0];
         default: ;
      endcase
   endtask

   // Hold off until every pixel is taken and every word has come, then let the pipe settle
   task automatic drain_block();
      while (pending_pixels.size() > 0 || req_valid || expected_words.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_kernel(input logic [KROW_BITS-1:0] top,
                             input logic [KROW_BITS-1:0] mid,
                             input logic [KROW_BITS-1:0] bot);
      csr_write(REG_KERNEL_TOP, {16'h0, top});
      csr_write(REG_KERNEL_MID, {16'h0, mid});
      csr_write(REG_KERNEL_BOT, {16'h0, bot});
   endtask

   function automatic logic [KROW_BITS-1:0] random_kernel_row();
      logic [KROW_BITS-1:0] row;
      for (int c = 0; c < 3; c++)
         if ($urandom_range(0, 2) == 0)
            row[c*COEF_BITS +: COEF_BITS] = 16'($urandom());
         else
            row[c*COEF_BITS +: COEF_BITS] = 16'($signed($urandom_range(0, 1024)) - 512);
      return row;
   endfunction

   // Queue one whole image; style 0 random, 1 extremes only, 2 near-flat
   task automatic queue_image(input int w_cfg, input int h_cfg, input int style);
      pixel_word_type p;
      int count;
      int base;
      count = clamp_size(w_cfg, MAX_WIDTH) * clamp_size(h_cfg, MAX_HEIGHT);
      base = $urandom_range(0, 255);
      for (int i = 0; i < count; i++) begin
         case (style)
            1: begin
               p.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               p.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            2: begin
               p.red = 8'(base + $urandom_range(0, 3));
               p.green = 8'(base + $urandom_range(0, 3));
               p.blue = 8'(base + $urandom_range(0, 3));
            end
            default: begin
               p.red = 8'($urandom());
               p.green = 8'($urandom());
               p.blue = 8'($urandom());
            end
         endcase
         pending_pixels.push_back(p);
      end
   endtask

   task automatic run_image(input int w_cfg, input int h_cfg, input int style);
      csr_write(REG_IMAGE_WIDTH, 64'(w_cfg));
      csr_write(REG_IMAGE_HEIGHT, 64'(h_cfg));
      queue_image(w_cfg, h_cfg, style);
      drain_block();
   endtask

   initial begin
      int sent;
      int w_cfg;
      int h_cfg;
      cfg_width = 12'd640;
      cfg_height = 13'd480;
      cfg_kernel[0] = '0;
      cfg_kernel[1] = 48'd256;
      cfg_kernel[2] = '0;
      cfg_gray = 1'b0;
      cfg_offset = 1'b0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         older_line[i] = '0;
         newer_line[i] = '0;
      end
      for (int i = 0; i < 9; i++) window[i] = '0;
      col_pos = 0;
      row_pos = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: identity kernel, extreme pixels, then extreme coefficients and modes
      run_image(3, 3, 1);
      set_kernel(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF);
      run_image(4, 3, 1);
      set_kernel(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000);
      csr_write(REG_OFFSET, 64'd1);
      run_image(0, 4, 1);
      set_kernel(48'h0001_FFFF_0080, 48'hFF00_0100_FF01, 48'h0000_FFFF_0001);
      csr_write(REG_GRAY, 64'd1);
      run_image(3, 1, 2);
      csr_write(REG_OFFSET, 64'd0);
      run_image(5, 3, 1);
      csr_write(REG_GRAY, 64'd0);

      // Random images, mostly small
      sent = 0;
      while (sent < 2000) begin
         set_kernel(random_kernel_row(), random_kernel_row(), random_kernel_row());
         csr_write(REG_GRAY, 64'($urandom_range(0, 1)));
         csr_write(REG_OFFSET, 64'($urandom_range(0, 1)));
         w_cfg = $urandom_range(0, 9) == 0 ? $urandom_range(0, 4095) % 200
                                            : $urandom_range(3, 12);
         h_cfg = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 9);
         sent += clamp_size(w_cfg, MAX_WIDTH) * clamp_size(h_cfg, MAX_HEIGHT);
         run_image(w_cfg, h_cfg, $urandom_range(0, 7) == 0 ? 1 :
                                 ($urandom_range(0, 7) == 0 ? 2 : 0));
      end

      if (mismatch_count == 0 && expected_words.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
